FILE: hdl/mfb_pkg.sv
// Package for the monochrome frame store plotter.
// Holds geometry constants, op codes, the plot request struct and pixel address helpers; no dependencies.
package mfb_pkg;
	localparam int COLUMNS = 128;
	localparam int PAGES = 8;
	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(COLUMNS);
	localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;

	localparam logic [2:0] OP_SET = 3'd0;
	localparam logic [2:0] OP_CLR = 3'd1;
	localparam logic [2:0] OP_LINE = 3'd2;
	localparam logic [2:0] OP_CIRC = 3'd3;
	localparam logic [2:0] OP_READ = 3'd4;

	typedef struct packed {
		logic       valid;
		logic       set;
		logic [7:0] x;
		logic [7:0] y;
	} plot_req_t;

	// Frame address of an in-frame pixel: column * PAGES + page.
	function automatic logic [AW-1:0] pix_addr(input logic [7:0] x, input logic [7:0] y);
		logic [AW+8:0] a;
		a = (AW+9)'(x) * (AW+9)'(PAGES) + (AW+9)'(y[7:3]);
		return a[AW-1:0];
	endfunction

	function automatic logic in_frame(input logic [7:0] x, input logic [7:0] y);
		return (32'(x) < COLUMNS) && (32'(y[7:3]) < PAGES);
	endfunction
endpackage

FILE: hdl/mfb_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

FILE: hdl/mono_framebuffer_line_circle_plotter.sv
// Plotter top level: command sequencer, one shared 9x9-bit multiplier and the frame RAM.
// Depends on mfb_pkg and mfb_ram.
// After reset a clearing pass writes zero to all DEPTH (1024) words before the first item is taken.
// Each in-frame pixel is a read-modify-write; a set or clear plots one pixel,
// a line plots its pixels after a restoring divide for the slope, and a circle plots 8
// pixels per step, then squares and tests in ST_CM3, ST_CCHK and ST_CM4, for radii up to 255.
// One item is worked at a time; the result register frees the input side once taken.
module mono_framebuffer_line_circle_plotter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: op[2:0], x_a[10:3], y_a[18:11], x_b[26:19], y_b[34:27], radius[42:35],
	// read_column[49:43], read_page[52:50]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: read_data[7:0], clipped[8]
	output logic [15:0] m_tdata
);
	import mfb_pkg::*;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_LINE  = 4'd3;
	localparam logic [3:0] ST_CM1   = 4'd4;
	localparam logic [3:0] ST_CM2   = 4'd5;
	localparam logic [3:0] ST_CPLOT = 4'd6;
	localparam logic [3:0] ST_CM3   = 4'd7;
	localparam logic [3:0] ST_CM4   = 4'd8;
	localparam logic [3:0] ST_CCHK  = 4'd9;
	localparam logic [3:0] ST_RD1   = 4'd10;
	localparam logic [3:0] ST_RD2   = 4'd11;
	localparam logic [3:0] ST_DONE  = 4'd12;
	localparam logic [3:0] ST_PIX   = 4'd13;

	localparam logic [1:0] PX_IDLE = 2'd0;
	localparam logic [1:0] PX_RD   = 2'd1;
	localparam logic [1:0] PX_WR   = 2'd2;

	logic [3:0]    state_q;
	logic [AW:0]   clr_q;
	logic [2:0]    op_q;
	logic [7:0]    xa_q, ya_q, xb_q, yb_q, rad_q;
	logic [CW-1:0] rcol_q;
	logic [2:0]    rpage_q;
	logic          clip_q;
	logic [7:0]    data_q;
	logic          res_v_q;
	logic [15:0]   res_q;

	// line walk
	logic [1:0]    lmode_q;     // 0 vertical, 1 horizontal, 2 sloped
	logic [7:0]    cnt_q, n_q;
	logic [7:0]    k_q;
	logic [8:0]    acc_q;       // partial remainder of the slope division
	logic [7:0]    quo_q;
	logic [3:0]    rem_q;
	logic [11:0]   dividend_q;
	logic [3:0]    dstep_q;
	logic [7:0]    in_dy;

	// k split into tens and units by a reciprocal multiply (exact for every 8-bit k).
	logic [15:0]   k_recip;
	logic [4:0]    k_div10;
	logic [7:0]    k_tens;
	logic [3:0]    k_mod10;

	// circle walk
	logic [8:0]    ca_q, cb_q;
	logic [16:0]   rr_q, bb_q, aa_q;
	logic [2:0]    oct_q;

	// shared multiplier
	logic [8:0]    mul_a, mul_b;
	logic [17:0]   mul_p;
	assign mul_p = mul_a * mul_b;

	// pixel read-modify-write unit
	logic [1:0]    px_q;
	plot_req_t     req;
	logic [AW-1:0] px_addr_q;
	logic [7:0]    px_mask_q;
	logic          px_set_q;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wd, ram_rd;

	mfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
	);

	assign s_tready = (state_q == ST_IDLE) && !res_v_q;
	assign m_tvalid = res_v_q;
	assign m_tdata  = res_q;

	assign in_dy   = s_tdata[34:27] - s_tdata[18:11];
	assign k_recip = 16'(k_q) * 16'd205;
	assign k_div10 = k_recip[15:11];
	assign k_tens  = 8'({3'd0, k_div10} * 8'd10);
	assign k_mod10 = 4'(k_q - k_tens);

	// Circle octant point selection.
	logic [7:0] cx, cy, ax8, bx8;
	assign ax8 = ca_q[7:0];
	assign bx8 = cb_q[7:0];
	always_comb begin
		case (oct_q)
			3'd0: begin cx = xa_q + ax8; cy = ya_q - bx8; end
			3'd1: begin cx = xa_q - ax8; cy = ya_q - bx8; end
			3'd2: begin cx = xa_q - ax8; cy = ya_q + bx8; end
			3'd3: begin cx = xa_q + ax8; cy = ya_q + bx8; end
			3'd4: begin cx = xa_q + bx8; cy = ya_q + ax8; end
			3'd5: begin cx = xa_q + bx8; cy = ya_q - ax8; end
			3'd6: begin cx = xa_q - bx8; cy = ya_q - ax8; end
			default: begin cx = xa_q - bx8; cy = ya_q + ax8; end
		endcase
	end

	logic [7:0] lx, ly;
	always_comb begin
		case (lmode_q)
			2'd0:    begin lx = xa_q; ly = ya_q + cnt_q; end
			2'd1:    begin lx = xa_q + cnt_q; ly = ya_q; end
			default: begin lx = xa_q + cnt_q; ly = ya_q + quo_q; end
		endcase
	end

	always_comb begin
		req = '0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_PIX: begin
				req.valid = (px_q == PX_IDLE); req.set = (op_q == OP_SET);
				req.x = xa_q; req.y = ya_q;
			end
			ST_LINE: begin
				req.valid = (px_q == PX_IDLE) && (cnt_q != n_q); req.set = 1'b1;
				req.x = lx; req.y = ly;
			end
			ST_CPLOT: begin
				req.valid = (px_q == PX_IDLE); req.set = 1'b1; req.x = cx; req.y = cy;
			end
			ST_CM1:  begin mul_a = {1'b0, rad_q}; mul_b = {1'b0, rad_q}; end
			ST_CM2, ST_CM4: begin mul_a = cb_q; mul_b = cb_q; end
			ST_CM3:  begin mul_a = ca_q; mul_b = ca_q; end
			default: ;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = px_addr_q;
		ram_wd = px_set_q ? (ram_rd | px_mask_q) : (ram_rd & ~px_mask_q);
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1; ram_addr = clr_q[AW-1:0]; ram_wd = '0;
		end else if (req.valid) begin
			ram_addr = pix_addr(req.x, req.y);
		end else if (px_q == PX_WR) begin
			ram_we = 1'b1;
		end else if (state_q == ST_RD1) begin
			ram_addr = AW'(32'(rcol_q) * PAGES + 32'(rpage_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= PX_IDLE;
		end else begin
			unique case (px_q)
				PX_IDLE: if (req.valid && in_frame(req.x, req.y)) px_q <= PX_RD;
				PX_RD:   px_q <= PX_WR;
				PX_WR:   px_q <= PX_IDLE;
				default: px_q <= PX_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			px_addr_q <= pix_addr(req.x, req.y);
			px_mask_q <= 8'(1) << req.y[2:0];
			px_set_q  <= req.set;
		end
	end

	logic pix_free;
	assign pix_free = req.valid && (!in_frame(req.x, req.y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			res_v_q <= 1'b0;
			clip_q <= 1'b0;
		end else begin
			if (res_v_q && m_tready) res_v_q <= 1'b0;
			if (req.valid && !in_frame(req.x, req.y)) clip_q <= 1'b1;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q[AW-1:0] == AW'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid && s_tready) begin
					op_q <= s_tdata[2:0];
					xa_q <= s_tdata[10:3];
					ya_q <= s_tdata[18:11];
					xb_q <= s_tdata[26:19];
					yb_q <= s_tdata[34:27];
					rad_q <= s_tdata[42:35];
					rcol_q <= CW'(s_tdata[49:43]);
					rpage_q <= s_tdata[52:50];
					clip_q <= 1'b0;
					data_q <= '0;
					cnt_q <= '0;
					quo_q <= '0;
					rem_q <= '0;
					acc_q <= '0;
					ca_q <= '0;
					cb_q <= {1'b0, s_tdata[42:35]};
					oct_q <= '0;
					unique case (s_tdata[2:0])
						OP_SET, OP_CLR: state_q <= ST_PIX;
						OP_LINE: begin
							if (s_tdata[10:3] == s_tdata[26:19]) begin
								lmode_q <= 2'd0;
								n_q <= (s_tdata[34:27] > s_tdata[18:11]) ?
									s_tdata[34:27] - s_tdata[18:11] : 8'd0;
								state_q <= ST_LINE;
							end else if (s_tdata[18:11] == s_tdata[34:27]) begin
								lmode_q <= 2'd1;
								n_q <= (s_tdata[26:19] > s_tdata[10:3]) ?
									s_tdata[26:19] - s_tdata[10:3] : 8'd0;
								state_q <= ST_LINE;
							end else begin
								lmode_q <= 2'd2;
								n_q <= (s_tdata[26:19] > s_tdata[10:3]) ?
									s_tdata[26:19] - s_tdata[10:3] : 8'd0;
								dividend_q <= {4'd0, in_dy} * 12'd10;
								k_q <= '0;
								dstep_q <= 4'd11;
								state_q <= ST_DIV;
							end
						end
						OP_CIRC: state_q <= ST_CM1;
						OP_READ: state_q <= ST_RD1;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_PIX: if (px_q == PX_WR || pix_free) state_q <= ST_DONE;
				ST_DIV: begin
					// Restoring division, one quotient bit per cycle; a 12-bit
					// quotient mod 256 keeps the low eight bits.
					logic [9:0] part;
					logic [8:0] dx;
					dx = {1'b0, xb_q - xa_q};
					part = {acc_q, dividend_q[dstep_q]};
					if (part >= {1'b0, dx}) begin
						acc_q <= 9'(part - {1'b0, dx});
						k_q <= {k_q[6:0], 1'b1};
					end else begin
						acc_q <= part[8:0];
						k_q <= {k_q[6:0], 1'b0};
					end
					dstep_q <= dstep_q - 1'b1;
					if (dstep_q == 4'd0) state_q <= ST_LINE;
				end
				ST_LINE: begin
					if (cnt_q == n_q) state_q <= ST_DONE;
					else if (px_q == PX_WR || pix_free) begin
						logic [4:0] s;
						logic [8:0] q;
						cnt_q <= cnt_q + 1'b1;
						// Add k to i*k kept as quotient and remainder by ten.
						s = 5'(rem_q) + 5'(k_mod10);
						q = 9'(quo_q) + 9'(k_div10);
						if (s >= 5'd10) begin
							rem_q <= 4'(s - 5'd10); quo_q <= 8'(q + 1'b1);
						end else begin
							rem_q <= 4'(s); quo_q <= 8'(q);
						end
					end
				end
				ST_CM1: begin
					rr_q <= mul_p[16:0];
					state_q <= ST_CM2;
				end
				ST_CM2: begin
					bb_q <= mul_p[16:0];
					if (rad_q == 8'd0) begin
						oct_q <= 3'd7;
						state_q <= ST_CPLOT;
					end else if ({mul_p[16:0], 1'b0} >= {1'b0, rr_q}) state_q <= ST_CPLOT;
					else state_q <= ST_DONE;
				end
				ST_CPLOT: if (px_q == PX_WR || pix_free) begin
					oct_q <= oct_q + 1'b1;
					if (oct_q == 3'd7) begin
						if (rad_q == 8'd0) state_q <= ST_DONE;
						else begin
							ca_q <= ca_q + 1'b1;
							state_q <= ST_CM3;
						end
					end
				end
				ST_CM3: begin
					aa_q <= mul_p[16:0];
					state_q <= ST_CCHK;
				end
				ST_CCHK: begin
					if (18'(aa_q) + 18'(bb_q) > 18'(rr_q)) begin
						cb_q <= cb_q - 1'b1;
						ca_q <= ca_q - 1'b1;
					end
					state_q <= ST_CM4;
				end
				ST_CM4: begin
					bb_q <= mul_p[16:0];
					if ({mul_p[16:0], 1'b0} >= {1'b0, rr_q}) state_q <= ST_CPLOT;
					else state_q <= ST_DONE;
				end
				ST_RD1: begin
					if (32'(rcol_q) < COLUMNS && 32'(rpage_q) < PAGES) state_q <= ST_RD2;
					else begin
						clip_q <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_RD2: begin
					data_q <= ram_rd;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					res_v_q <= 1'b1;
					res_q <= {7'd0, clip_q, data_q};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
